@@ hw/rtl/poc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Precedence order checker package
// Shared sizes, payload types and the command and status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package poc_pkg;

  localparam int unsigned PAGES   = 128;
  localparam int unsigned MAX_LEN = 32;

  localparam int unsigned PAGE_W = 7;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned PIDX_W = $clog2(PAGES);
  localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned BUF_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [PIDX_W-1:0] pidx_t;

  typedef enum logic {
    MODE_RULE = 1'b0,
    MODE_PAGE = 1'b1
  } mode_e;

  typedef struct packed {
    logic  mode;
    page_t before_page;
    page_t after_page;
    page_t page;
    logic  booklet_end;
  } in_item_t;

  typedef struct packed {
    page_t            out_page;
    logic [POS_W-1:0] position;
    logic             is_middle;
    logic             in_order;
    logic             overflow;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic rule_wr;
    logic check;
    logic scan_shift;
    logic place;
    logic emit_rd;
    logic emit_ld;
    logic emit_next;
    logic clear;
  } poc_cmd_t;

  typedef struct packed {
    logic full;
    logic len_zero;
    logic hit;
    logic i_one;
    logic booklet_end;
    logic emit_last;
  } poc_status_t;

  // Matrix and candidate index of a page: the page number modulo PAGES.
  function automatic pidx_t page_index(input page_t p);
    if (PAGES >= (1 << PAGE_W)) begin
      return PIDX_W'(p);
    end else begin
      return PIDX_W'(p % PAGES);
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/poc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Precedence order checker channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface poc_in_if import poc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface poc_out_if import poc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/poc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module poc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hw/rtl/poc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Precedence order checker datapath
// Precedence matrix, candidate map, arrival and sorted buffers, booklet
// bookkeeping and the result register.
// ----------------------------------------------------------------------------
module poc_datapath import poc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire in_item_t    in_data_i,
  input  wire poc_cmd_t    cmd_i,
  output poc_status_t      status_o,
  output out_item_t        out_data_o
);

  in_item_t              item_q;
  logic [LEN_W-1:0]      len_q;
  logic                  ok_q;
  logic                  drop_q;
  logic [PAGES-1:0]      cand_q;
  logic [PAGES-1:0]      mvalid_q;
  logic [PAGES-1:0]      pred_q;
  logic [LEN_W-1:0]      i_q;
  logic [LEN_W-1:0]      k_q;
  out_item_t             out_q;

  logic [PAGES-1:0]      mat_rdata;
  logic [PAGES-1:0]      mat_word;
  logic [PAGES-1:0]      mat_wdata;
  pidx_t                 mat_raddr;
  pidx_t                 row_idx;
  pidx_t                 col_idx;
  pidx_t                 item_idx;
  logic                  full;
  logic                  in_is_page;

  page_t                 srt_rdata;
  page_t                 srt_wdata;
  page_t                 arr_rdata;
  logic [BUF_AW-1:0]     srt_raddr;
  logic                  srt_we;
  logic [LEN_W-1:0]      len_m1;
  logic [LEN_W-1:0]      i_m2;
  logic [LEN_W-1:0]      k_p1;

  assign full       = (len_q == LEN_W'(MAX_LEN));
  assign in_is_page = (mode_e'(in_data_i.mode) == MODE_PAGE);
  assign item_idx   = page_index(item_q.page);
  assign row_idx    = page_index(item_q.before_page);
  assign col_idx    = page_index(item_q.after_page);
  assign mat_raddr  = in_is_page ? page_index(in_data_i.page) :
                                   page_index(in_data_i.after_page);

  // A column that was never written holds no rules.
  assign mat_word  = (mode_e'(item_q.mode) == MODE_PAGE) ?
                     (mvalid_q[item_idx] ? mat_rdata : '0) :
                     (mvalid_q[col_idx] ? mat_rdata : '0);
  assign mat_wdata = mat_word | ({{(PAGES-1){1'b0}}, 1'b1} << row_idx);

  // Column word at page b holds bit a set when page a must precede page b.
  poc_ram #(
    .Width (PAGES),
    .Depth (PAGES)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rule_wr),
    .waddr_i (col_idx),
    .wdata_i (mat_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  poc_ram #(
    .Width (PAGE_W),
    .Depth (MAX_LEN)
  ) u_arrival (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && in_is_page && !full),
    .waddr_i (len_q[BUF_AW-1:0]),
    .wdata_i (in_data_i.page),
    .re_i    (cmd_i.emit_rd),
    .raddr_i (k_q[BUF_AW-1:0]),
    .rdata_o (arr_rdata)
  );

  assign len_m1    = len_q - LEN_W'(1);
  assign i_m2      = i_q - LEN_W'(2);
  assign k_p1      = k_q + LEN_W'(1);
  assign srt_raddr = cmd_i.emit_rd ? k_q[BUF_AW-1:0] :
                     (cmd_i.check ? len_m1[BUF_AW-1:0] : i_m2[BUF_AW-1:0]);
  assign srt_we    = cmd_i.scan_shift || cmd_i.place;
  assign srt_wdata = cmd_i.place ? item_q.page : srt_rdata;

  poc_ram #(
    .Width (PAGE_W),
    .Depth (MAX_LEN)
  ) u_sorted (
    .clk_i   (clk_i),
    .we_i    (srt_we),
    .waddr_i (i_q[BUF_AW-1:0]),
    .wdata_i (srt_wdata),
    .re_i    (cmd_i.emit_rd || cmd_i.check || cmd_i.scan_shift),
    .raddr_i (srt_raddr),
    .rdata_o (srt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ok_q     <= 1'b1;
      drop_q   <= 1'b0;
      cand_q   <= '1;
      mvalid_q <= '0;
      k_q      <= '0;
    end else begin
      if (cmd_i.accept && in_is_page && full) begin
        drop_q <= 1'b1;
      end
      if (cmd_i.rule_wr) begin
        mvalid_q[col_idx] <= 1'b1;
      end
      if (cmd_i.check && ok_q) begin
        if (!cand_q[item_idx]) begin
          ok_q <= 1'b0;
        end else begin
          cand_q <= cand_q & ~mat_word & ~({{(PAGES-1){1'b0}}, 1'b1} << item_idx);
        end
      end
      if (cmd_i.place) begin
        len_q <= len_q + LEN_W'(1);
      end
      if (cmd_i.emit_next) begin
        k_q <= k_p1;
      end
      if (cmd_i.clear) begin
        len_q  <= '0;
        ok_q   <= 1'b1;
        drop_q <= 1'b0;
        cand_q <= '1;
        k_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.check) begin
      pred_q <= mat_word;
      i_q    <= len_q;
    end
    if (cmd_i.scan_shift) begin
      i_q <= i_q - LEN_W'(1);
    end
    if (cmd_i.emit_ld) begin
      out_q.out_page  <= ok_q ? arr_rdata : srt_rdata;
      out_q.position  <= POS_W'(k_q);
      out_q.is_middle <= (k_q == (len_q >> 1));
      out_q.in_order  <= ok_q;
      out_q.overflow  <= drop_q;
      out_q.last      <= (k_p1 == len_q);
    end
  end

  assign status_o.full        = full;
  assign status_o.len_zero    = (len_q == '0);
  assign status_o.hit         = pred_q[page_index(srt_rdata)];
  assign status_o.i_one       = (i_q == LEN_W'(1));
  assign status_o.booklet_end = item_q.booklet_end;
  assign status_o.emit_last   = (k_p1 == len_q);

  assign out_data_o = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/poc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Precedence order checker controller
// Sequences rule writes, page checks, the insertion scan and booklet output.
// ----------------------------------------------------------------------------
module poc_ctrl import poc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_mode_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire poc_status_t status_i,
  output poc_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RULE,
    S_CHECK,
    S_SCAN,
    S_PLACE,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (mode_e'(in_mode_i) == MODE_PAGE) ? S_CHECK : S_RULE;
        end
      end
      S_RULE: begin
        cmd_o.rule_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_CHECK: begin
        if (status_i.full) begin
          state_d = status_i.booklet_end ? S_EMIT_RD : S_IDLE;
        end else begin
          cmd_o.check = 1'b1;
          state_d = status_i.len_zero ? S_PLACE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.hit) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.scan_shift = 1'b1;
          if (status_i.i_one) begin
            state_d = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d = status_i.booklet_end ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        if (status_i.len_zero) begin
          cmd_o.clear = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.emit_rd = 1'b1;
          state_d = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd_o.emit_ld = 1'b1;
        out_valid_d = 1'b1;
        state_d = S_EMIT_HOLD;
      end
      S_EMIT_HOLD: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (status_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ hw/rtl/precedence_order_checker_sorter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Precedence order checker and sorter
// Loads precedence rules, checks booklets against them and emits each
// booklet in arrival order or in insertion-sorted order.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A rule is handled as a read and then a
// write of one column of the precedence matrix RAM. A page is handled as
// the matrix column read, the order check, then the insertion scan, which
// walks the sorted buffer RAM one entry per cycle through its single read
// port, and last the placing of the page. A page that arrives when the
// booklet is full is dropped without a check and marks the booklet as
// overflowed. At the end of a booklet every result is read from a buffer
// RAM, registered and held until the sink takes it, and only then is the
// next result read. The matrix needs no clearing pass after reset: each
// column carries a valid bit, and a column never written reads as holding
// no rules.
// ----------------------------------------------------------------------------
module precedence_order_checker_sorter import poc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  poc_in_if.sink     in_i,
  poc_out_if.source  out_o
);

  poc_cmd_t    cmd;
  poc_status_t status;

  poc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.data.mode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  poc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_o.data)
  );

endmodule
`default_nettype wire

@@ sim/poc_booklet_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Booklet checker for the precedence order checker and sorter
// Watches both channels. Every accepted input transfer updates a private
// copy of the precedence rules and the booklet state. Each booklet end queues
// the entries the block must emit, and each accepted result transfer is
// compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module poc_booklet_checker import poc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  poc_in_if         in_i,
  poc_out_if        out_i,
  output int        fail_count_o,
  output int        pending_o
);

  bit [PAGES-1:0] precedes [PAGES];
  bit [PAGES-1:0] candidates;
  page_t          arrival_pages [MAX_LEN];
  page_t          sorted_pages [MAX_LEN];
  int unsigned    held_count;
  bit             in_sequence;
  bit             pages_dropped;
  out_item_t      booklet_entries_q [$];
  int             fail_count;
  int             pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic pidx_t index_of(input page_t pg);
    return pidx_t'(pg % PAGES);
  endfunction

  task automatic clear_booklet();
    candidates    = '1;
    held_count    = 0;
    in_sequence   = 1'b1;
    pages_dropped = 1'b0;
  endtask

  task automatic take_page(input page_t pg, input logic booklet_end);
    pidx_t       idx;
    int unsigned slot;
    int unsigned k;
    out_item_t   entry;
    idx = index_of(pg);
    if (held_count < MAX_LEN) begin
      if (in_sequence) begin
        if (!candidates[idx]) begin
          in_sequence = 1'b0;
        end else begin
          candidates[idx] = 1'b0;
          for (k = 0; k < PAGES; k++) begin
            if (precedes[k][idx]) candidates[k] = 1'b0;
          end
        end
      end
      slot = held_count;
      while (slot > 0 && !precedes[index_of(sorted_pages[slot-1])][idx]) slot--;
      for (k = held_count; k > slot; k--) sorted_pages[k] = sorted_pages[k-1];
      sorted_pages[slot]        = pg;
      arrival_pages[held_count] = pg;
      held_count++;
    end else begin
      pages_dropped = 1'b1;
    end
    if (booklet_end) begin
      for (k = 0; k < held_count; k++) begin
        entry.out_page  = in_sequence ? arrival_pages[k] : sorted_pages[k];
        entry.position  = POS_W'(k);
        entry.is_middle = (k == held_count / 2);
        entry.in_order  = in_sequence;
        entry.overflow  = pages_dropped;
        entry.last      = (k + 1 == held_count);
        booklet_entries_q = {booklet_entries_q, entry};
      end
      clear_booklet();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      foreach (precedes[a]) precedes[a] = '0;
      clear_booklet();
      booklet_entries_q.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (booklet_entries_q.size() == 0) begin
          $error("Unexpected result transfer: out_page %0d position %0d",
                 out_i.data.out_page, out_i.data.position);
          fail_count++;
        end else begin
          exp_item = booklet_entries_q.pop_front();
          check_field("out_page", 32'(exp_item.out_page), 32'(out_i.data.out_page));
          check_field("position", 32'(exp_item.position), 32'(out_i.data.position));
          check_field("is_middle", 32'(exp_item.is_middle), 32'(out_i.data.is_middle));
          check_field("in_order", 32'(exp_item.in_order), 32'(out_i.data.in_order));
          check_field("overflow", 32'(exp_item.overflow), 32'(out_i.data.overflow));
          check_field("last", 32'(exp_item.last), 32'(out_i.data.last));
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.data.mode == MODE_RULE) begin
          precedes[index_of(in_i.data.before_page)][index_of(in_i.data.after_page)] = 1'b1;
        end else begin
          take_page(in_i.data.page, in_i.data.booklet_end);
        end
      end
      pending = booklet_entries_q.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the precedence order checker and sorter
// Drives precedence rules and booklets: a directed set of corner cases, then
// random phases of mostly consistent rules over a small page pool followed by
// booklets in rule order or shuffled, with noise, repeated pages, a full
// booklet and an overflowing one. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import poc_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 100;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 50;

  logic        clk_i;
  logic        rst_ni;
  bit          calm;
  int unsigned sent_count;
  int          fail_count;
  int          pending;

  poc_in_if  in_ch ();
  poc_out_if out_ch ();

  precedence_order_checker_sorter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  poc_booklet_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= (!calm && $urandom_range(99) < 17) ? 1'b0 : 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic in_item_t rule_item(input page_t first, input page_t later);
    in_item_t it;
    it.mode        = MODE_RULE;
    it.before_page = first;
    it.after_page  = later;
    it.page        = page_t'($urandom);
    it.booklet_end = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t page_item(input page_t pg, input logic booklet_end);
    in_item_t it;
    it.mode        = MODE_PAGE;
    it.before_page = page_t'($urandom);
    it.after_page  = page_t'($urandom);
    it.page        = pg;
    it.booklet_end = booklet_end;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_booklet(input page_t pages [$]);
    for (int k = 0; k < pages.size(); k++) begin
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1)) begin
          send_item(rule_item(page_t'($urandom), page_t'($urandom)));
        end else begin
          send_item(page_item(page_t'($urandom), 1'($urandom)));
        end
      end
      send_item(page_item(pages[k], k == pages.size() - 1));
    end
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    page_t       pool [$];
    page_t       picks [$];
    page_t       tmp;
    int unsigned pool_n;
    int unsigned first;
    int unsigned later;
    int unsigned len;
    int unsigned j;
    int unsigned booklet_no;
    int unsigned phase_no;
    int unsigned directed_count;

    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_ni      = 1'b0;
    calm        = 1'b0;
    sent_count  = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(page_item(7'd0, 1'b1));
    send_item(rule_item(7'd0, 7'd127));
    send_item(rule_item(7'd0, 7'd127));
    send_item(rule_item(7'd5, 7'd5));
    send_item(page_item(7'd127, 1'b0));
    send_item(page_item(7'd0, 1'b1));
    send_item(page_item(7'd0, 1'b0));
    send_item(page_item(7'd127, 1'b1));
    send_item(page_item(7'd5, 1'b0));
    send_item(page_item(7'd5, 1'b1));
    send_item(page_item(7'd10, 1'b0));
    send_item(rule_item(7'd20, 7'd10));
    send_item(page_item(7'd20, 1'b1));
    send_item(rule_item(7'd1, 7'd2));
    send_item(rule_item(7'd2, 7'd3));
    send_item(page_item(7'd3, 1'b0));
    send_item(page_item(7'd2, 1'b0));
    send_item(page_item(7'd1, 1'b1));
    send_item(page_item(7'd1, 1'b0));
    send_item(page_item(7'd2, 1'b0));
    send_item(page_item(7'd3, 1'b1));
    directed_count = sent_count;

    booklet_no = 0;
    phase_no   = 0;
    while (sent_count < directed_count + RANDOM_ITEMS || booklet_no <= 6) begin
      calm = (phase_no == 1);
      pool.delete();
      pool_n = $urandom_range(4, 8);
      repeat (pool_n) pool = {pool, page_t'($urandom)};
      repeat (pool_n) begin
        first = $urandom_range(0, pool_n - 2);
        later = $urandom_range(first + 1, pool_n - 1);
        if ($urandom_range(9) == 0) begin
          send_item(rule_item(pool[later], pool[first]));
        end else begin
          send_item(rule_item(pool[first], pool[later]));
        end
      end
      repeat ($urandom_range(2, 4)) begin
        picks.delete();
        if (booklet_no == 3) begin
          len = MAX_LEN;
        end else if (booklet_no == 6) begin
          len = $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
        end else begin
          len = 0;
        end
        if (len != 0) begin
          repeat (len) picks = {picks, page_t'($urandom)};
        end else begin
          foreach (pool[k]) begin
            if ($urandom_range(1)) picks = {picks, pool[k]};
          end
          if (picks.size() == 0) picks = {picks, pool[0]};
          if ($urandom_range(1)) begin
            for (int k = picks.size() - 1; k > 0; k--) begin
              j        = $urandom_range(0, k);
              tmp      = picks[k];
              picks[k] = picks[j];
              picks[j] = tmp;
            end
          end
          if ($urandom_range(9) == 0) picks = {picks, picks[0]};
        end
        send_booklet(picks);
        booklet_no++;
        if (booklet_no == 5) wait_all_results();
      end
      phase_no++;
    end
    calm = 1'b0;

    wait_all_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending != 0) $error("%0d booklet entries never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/poc_pkg.sv
hw/rtl/poc_if.sv
hw/rtl/poc_ram.sv
hw/rtl/poc_datapath.sv
hw/rtl/poc_ctrl.sv
hw/rtl/precedence_order_checker_sorter.sv
sim/poc_booklet_checker.sv
sim/testbench.sv
